FILE: src/alt_pkg.sv
package alt_pkg;

   typedef enum logic [1:0] {
      MODE_INSERT,
      MODE_READ,
      MODE_REMOVE,
      MODE_SEARCH
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_FULL,
      ST_DUP,
      ST_BADPOS,
      ST_MISSING
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SHIFT,
      S_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] read_value;
      logic [3:0]         found_position;
      logic [4:0]         count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       issue;
      logic       append;
      logic       shift;
      logic       dec;
      logic       fin;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     bad_pos;
      logic     issue_ok;
      logic     rd_vld;
      logic     hit;
      logic     rd_last;
      logic     out_free;
   } dp_sts_type;

endpackage

FILE: src/alt_ctrl.sv
module alt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  alt_pkg::dp_sts_type sts,
   output alt_pkg::dp_cmd_type cmd
);
   import alt_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (sts.mode)
               MODE_INSERT: begin
                  if (sts.full) begin
                     code_in  = ST_FULL;
                     state_in = S_DONE;
                  end else if (!sts.issue_ok) begin
                     cmd.append = 1'b1;
                     code_in    = ST_OK;
                     state_in   = S_DONE;
                  end else begin
                     cmd.issue = 1'b1;
                     state_in  = S_SCAN;
                  end
               end
               MODE_SEARCH: begin
                  if (!sts.issue_ok) begin
                     code_in  = ST_MISSING;
                     state_in = S_DONE;
                  end else begin
                     cmd.issue = 1'b1;
                     state_in  = S_SCAN;
                  end
               end
               MODE_READ: begin
                  if (sts.bad_pos) begin
                     code_in  = ST_BADPOS;
                     state_in = S_DONE;
                  end else begin
                     cmd.issue = 1'b1;
                     state_in  = S_WAIT;
                  end
               end
               MODE_REMOVE: begin
                  if (sts.bad_pos) begin
                     code_in  = ST_BADPOS;
                     state_in = S_DONE;
                  end else if (!sts.issue_ok) begin
                     cmd.dec  = 1'b1;
                     code_in  = ST_OK;
                     state_in = S_DONE;
                  end else begin
                     cmd.issue = 1'b1;
                     state_in  = S_SHIFT;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (sts.hit) begin
               code_in  = (sts.mode == MODE_INSERT) ? ST_DUP : ST_OK;
               state_in = S_DONE;
            end else if (sts.rd_last) begin
               if (sts.mode == MODE_INSERT) begin
                  cmd.append = 1'b1;
                  code_in    = ST_OK;
               end else begin
                  code_in = ST_MISSING;
               end
               state_in = S_DONE;
            end else if (sts.issue_ok) begin
               cmd.issue = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift = sts.rd_vld;
            if (sts.rd_last) begin
               cmd.dec  = 1'b1;
               code_in  = ST_OK;
               state_in = S_DONE;
            end else if (sts.issue_ok) begin
               cmd.issue = 1'b1;
            end
         end
         S_WAIT: begin
            code_in  = ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: src/alt_dpath.sv
module alt_dpath #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  alt_pkg::req_type    req_data,
   output alt_pkg::rsp_type    rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  alt_pkg::dp_cmd_type cmd,
   output alt_pkg::dp_sts_type sts
);
   import alt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 4) ? CW : 4;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   mode_type              mode_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [3:0]            pos_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [CW-1:0]         rd_idx_ff;
   logic                  rd_vld_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         shift_addr;

   assign shift_addr = rd_idx_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_data.mode;
         value_ff <= DATA_WIDTH'(req_data.value);
         pos_ff   <= req_data.position;
      end
      if (cmd.issue) begin
         rdata_ff  <= mem[idx_ff[AW-1:0]];
         rd_idx_ff <= idx_ff;
      end
      if (cmd.append) begin
         mem[count_ff[AW-1:0]] <= value_ff;
      end else if (cmd.shift) begin
         mem[shift_addr[AW-1:0]] <= rdata_ff;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         case (req_data.mode)
            MODE_READ:   idx_in = CW'(req_data.position);
            MODE_REMOVE: idx_in = CW'(req_data.position) + CW'(1);
            default:     idx_in = '0;
         endcase
      end else if (cmd.issue) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.fin) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = cmd.code;
         rsp_in.count          = 5'(count_ff);
         rsp_in.read_value     = '0;
         rsp_in.found_position = '0;
         if (cmd.code == ST_OK && mode_ff == MODE_READ) begin
            rsp_in.read_value = 32'(rdata_ff);
         end
         if (cmd.code == ST_OK && mode_ff == MODE_SEARCH) begin
            rsp_in.found_position = 4'(rd_idx_ff);
         end
      end
   end

   always_comb begin
      sts.mode     = mode_ff;
      sts.full     = (count_ff == CW'(CAPACITY));
      sts.bad_pos  = (XW'(pos_ff) >= XW'(count_ff));
      sts.issue_ok = (idx_ff < count_ff);
      sts.rd_vld   = rd_vld_ff;
      sts.hit      = rd_vld_ff && (rdata_ff == value_ff);
      sts.rd_last  = rd_vld_ff && (rd_idx_ff == (count_ff - CW'(1)));
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (count_ff < CW'(CAPACITY)))
      else $error("append into full list");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.append && cmd.shift))
      else $error("append and shift collide");

   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> sts.out_free)
      else $error("result overwrites pending item");

   a_dec_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.dec |-> (count_ff != '0))
      else $error("remove from empty list");
`endif

endmodule

FILE: src/array_list_table.sv
// channel  ports                          payload
// req      req_valid, req_stall, req_data   mode, value, position
// rsp      rsp_valid, rsp_stall, rsp_data   status, read_value, found_position, count
//
// One item at a time; the entry memory has one read port, walked one entry per cycle.
// From acceptance to result, a read fetches the entry at position, insert and search walk
// from entry 0 to a match or the last entry, and remove shifts the entries above position down,
// plus any wait on a stalled result; the next item can be taken in the cycle the result is presented.
// Synchronous active-high reset clears the count and handshake state; entries are not cleared.
// A stalled result holds in the output register while the next item is accepted.
module array_list_table #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  alt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output alt_pkg::rsp_type rsp_data
);
   import alt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   alt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   alt_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
